// ===== design/sxe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sxe_pkg;

    // default stack depth, queue depth and fixed field widths
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 2;
    localparam int STATUS_W        = 3;
    localparam int LEVEL_W         = 11;
    localparam int CHAR_W          = 8;

    // character codes that matter to the scan
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BQUOTE = 8'h60;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    typedef enum logic [STATUS_W-1:0] {
        ST_SCAN     = 3'd0,
        ST_END      = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_UNTERM   = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_IDLE     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        GRP_BRACE  = 2'd0,
        GRP_DOUBLE = 2'd1,
        GRP_SINGLE = 2'd2
    } group_t;

    typedef enum logic [3:0] {
        CLS_OTHER  = 4'd0,
        CLS_BSLASH = 4'd1,
        CLS_DOLLAR = 4'd2,
        CLS_SQUOTE = 4'd3,
        CLS_DQUOTE = 4'd4,
        CLS_BQUOTE = 4'd5,
        CLS_LBRACE = 4'd6,
        CLS_RBRACE = 4'd7,
        CLS_LPAREN = 4'd8,
        CLS_RPAREN = 4'd9
    } char_cls_t;

    // one classified character as it sits in the queue
    typedef struct packed {
        char_cls_t cls;
        logic      pair;
        logic      has_next;
        logic      begin_scan;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

`default_nettype wire

// ===== design/sxe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sxe_char_if;
    logic                         valid;
    logic                         ready;
    logic [sxe_pkg::CHAR_W-1:0]   char_code;
    logic [sxe_pkg::CHAR_W-1:0]   next_code;
    logic                         has_next;
    logic                         begin_scan;

    modport source (output valid, char_code, next_code, has_next, begin_scan, input ready);
    modport sink   (input valid, char_code, next_code, has_next, begin_scan, output ready);
endinterface

interface sxe_result_if;
    logic                         valid;
    logic                         ready;
    logic [sxe_pkg::STATUS_W-1:0] status;
    logic [sxe_pkg::LEVEL_W-1:0]  stack_level;

    modport source (output valid, status, stack_level, input ready);
    modport sink   (input valid, status, stack_level, output ready);
endinterface

`default_nettype wire

// ===== design/sxe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxe_front (
    sxe_char_if.sink        chars,
    input  wire logic       q_full,
    output sxe_pkg::item_t  push_item,
    output logic            push
);

    sxe_pkg::char_cls_t cls;

    assign chars.ready = !q_full;
    assign push        = chars.valid && !q_full;

    always_comb
    begin
        case (chars.char_code)
            sxe_pkg::CH_BSLASH: cls = sxe_pkg::CLS_BSLASH;
            sxe_pkg::CH_DOLLAR: cls = sxe_pkg::CLS_DOLLAR;
            sxe_pkg::CH_SQUOTE: cls = sxe_pkg::CLS_SQUOTE;
            sxe_pkg::CH_DQUOTE: cls = sxe_pkg::CLS_DQUOTE;
            sxe_pkg::CH_BQUOTE: cls = sxe_pkg::CLS_BQUOTE;
            sxe_pkg::CH_LBRACE: cls = sxe_pkg::CLS_LBRACE;
            sxe_pkg::CH_RBRACE: cls = sxe_pkg::CLS_RBRACE;
            sxe_pkg::CH_LPAREN: cls = sxe_pkg::CLS_LPAREN;
            sxe_pkg::CH_RPAREN: cls = sxe_pkg::CLS_RPAREN;
            default:            cls = sxe_pkg::CLS_OTHER;
        endcase
    end

    // doubled paren lookahead: same paren follows
    always_comb
    begin
        push_item.cls        = cls;
        push_item.pair       = chars.has_next && (chars.next_code == chars.char_code) &&
                               ((cls == sxe_pkg::CLS_LPAREN) || (cls == sxe_pkg::CLS_RPAREN));
        push_item.has_next   = chars.has_next;
        push_item.begin_scan = chars.begin_scan;
    end

endmodule

`default_nettype wire

// ===== design/sxe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxe_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sxe_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output sxe_pkg::head_t       head
);

    localparam int PW = (sxe_pkg::QUEUE_DEPTH > 1) ? $clog2(sxe_pkg::QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(sxe_pkg::QUEUE_DEPTH + 1);

    sxe_pkg::item_t  ent_reg [sxe_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg,   fill_next;

    assign full       = (fill_reg == FW'(sxe_pkg::QUEUE_DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.item  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(sxe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(sxe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/sxe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxe_back #(
    parameter int STACK_DEPTH = sxe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sxe_pkg::head_t  head,
    output logic                 pop,
    sxe_result_if.source         results
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = (CW > sxe_pkg::LEVEL_W) ? CW : sxe_pkg::LEVEL_W;

    // lower stack entries; the top entry and the one below sit in registers
    sxe_pkg::group_t stack_mem [STACK_DEPTH];

    logic [CW-1:0]   cnt_reg, cnt_next, cnt_eff, rd_cnt;
    sxe_pkg::group_t top_reg, top_next;
    sxe_pkg::group_t below_reg;
    logic            sq_reg, sq_next;
    logic            dq_reg, dq_next;
    logic            bq_reg, bq_next;
    logic            bs_reg, bs_next;
    logic            dl_reg, dl_next;
    logic            skip_reg, skip_next;
    logic            fin_reg, fin_next;
    logic            out_valid_reg;
    sxe_pkg::status_t status_reg, status_next;
    logic [sxe_pkg::LEVEL_W-1:0] level_reg;
    logic [LW-1:0]   level_wide;

    logic            fire;
    logic            do_push, do_pop, evaluate, keep, active, stack_full, stack_empty, opened;
    sxe_pkg::group_t push_kind;
    logic            mem_we;
    logic [AW-1:0]   mem_wa, mem_ra;

    assign fire = head.valid && (!out_valid_reg || results.ready);
    assign pop  = fire;

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.stack_level = level_reg;

    always_comb
    begin
        sq_next     = sq_reg;
        dq_next     = dq_reg;
        bq_next     = bq_reg;
        bs_next     = bs_reg;
        dl_next     = dl_reg;
        skip_next   = skip_reg;
        fin_next    = fin_reg;
        cnt_eff     = cnt_reg;
        cnt_next    = cnt_reg;
        top_next    = top_reg;
        status_next = sxe_pkg::ST_IDLE;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        push_kind   = sxe_pkg::GRP_BRACE;
        evaluate    = 1'b1;
        keep        = 1'b0;
        active      = 1'b0;
        opened      = 1'b0;

        if (head.item.begin_scan)
        begin
            sq_next   = 1'b0;
            dq_next   = 1'b0;
            bq_next   = 1'b0;
            bs_next   = 1'b0;
            dl_next   = 1'b0;
            skip_next = 1'b0;
            fin_next  = 1'b0;
            cnt_eff   = '0;
            cnt_next  = '0;
        end

        stack_full  = (cnt_eff == CW'(STACK_DEPTH));
        stack_empty = (cnt_eff == '0);

        if (head.item.begin_scan || !fin_reg)
        begin
            status_next = sxe_pkg::ST_SCAN;
            if (skip_next)
            begin
                // second char of a doubled paren
                skip_next = 1'b0;
            end
            else
            begin
                active = !bs_next && !(sq_next || dq_next || bq_next);
                case (head.item.cls)
                    sxe_pkg::CLS_BSLASH:
                    begin
                        if (!sq_next)
                        begin
                            bs_next = !bs_next;
                            dl_next = 1'b0;
                            keep    = 1'b1;
                        end
                    end
                    sxe_pkg::CLS_DOLLAR:
                    begin
                        if (active && !dl_next)
                        begin
                            dl_next = 1'b1;
                            keep    = 1'b1;
                        end
                    end
                    sxe_pkg::CLS_SQUOTE:
                    begin
                        if (!dq_next && !bq_next)
                        begin
                            sq_next = !sq_next;
                        end
                    end
                    sxe_pkg::CLS_DQUOTE:
                    begin
                        if (!bs_next && !sq_next && !bq_next)
                        begin
                            dq_next = !dq_next;
                        end
                    end
                    sxe_pkg::CLS_BQUOTE:
                    begin
                        if (!bs_next && !dq_next && !sq_next)
                        begin
                            bq_next = !bq_next;
                        end
                    end
                    sxe_pkg::CLS_LBRACE:
                    begin
                        if (dl_next && active)
                        begin
                            if (stack_full)
                            begin
                                status_next = sxe_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                do_push   = 1'b1;
                                push_kind = sxe_pkg::GRP_BRACE;
                            end
                        end
                    end
                    sxe_pkg::CLS_LPAREN:
                    begin
                        if (active)
                        begin
                            if (stack_full)
                            begin
                                status_next = sxe_pkg::ST_OVERFLOW;
                            end
                            else if (head.item.pair)
                            begin
                                do_push   = 1'b1;
                                push_kind = sxe_pkg::GRP_DOUBLE;
                                skip_next = 1'b1;
                                evaluate  = 1'b0;
                            end
                            else
                            begin
                                do_push   = 1'b1;
                                push_kind = sxe_pkg::GRP_SINGLE;
                            end
                        end
                    end
                    sxe_pkg::CLS_RBRACE:
                    begin
                        if (active)
                        begin
                            if (stack_empty)
                            begin
                                status_next = sxe_pkg::ST_MISMATCH;
                            end
                            else
                            begin
                                do_pop = 1'b1;
                                if (top_reg != sxe_pkg::GRP_BRACE)
                                begin
                                    status_next = sxe_pkg::ST_MISMATCH;
                                end
                            end
                        end
                    end
                    sxe_pkg::CLS_RPAREN:
                    begin
                        if (active)
                        begin
                            if (stack_empty)
                            begin
                                status_next = sxe_pkg::ST_MISMATCH;
                            end
                            else
                            begin
                                do_pop = 1'b1;
                                if (head.item.pair && (top_reg == sxe_pkg::GRP_DOUBLE))
                                begin
                                    skip_next = 1'b1;
                                    evaluate  = 1'b0;
                                end
                                else if (top_reg != sxe_pkg::GRP_SINGLE)
                                begin
                                    status_next = sxe_pkg::ST_MISMATCH;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        keep = 1'b0;
                    end
                endcase

                if (!keep)
                begin
                    bs_next = 1'b0;
                    dl_next = 1'b0;
                end
            end

            if (do_push)
            begin
                cnt_next = cnt_eff + CW'(1);
                top_next = push_kind;
            end
            else if (do_pop)
            begin
                cnt_next = cnt_eff - CW'(1);
                top_next = below_reg;
            end

            opened = sq_next || dq_next || bq_next || (cnt_next != '0);
            if (status_next != sxe_pkg::ST_SCAN)
            begin
                fin_next  = 1'b1;
                skip_next = 1'b0;
            end
            else if (evaluate)
            begin
                if (!head.item.has_next)
                begin
                    status_next = opened ? sxe_pkg::ST_UNTERM : sxe_pkg::ST_END;
                    fin_next    = 1'b1;
                end
                else if (!opened && !dl_next)
                begin
                    status_next = sxe_pkg::ST_END;
                    fin_next    = 1'b1;
                end
            end
        end
    end

    assign level_wide = LW'(cnt_next);

    // the old top moves into memory on a push; the entry below the new top is read ahead
    assign mem_we = fire && do_push && !stack_empty;
    assign mem_wa = AW'(cnt_eff - CW'(1));
    assign rd_cnt = fire ? cnt_next : cnt_reg;
    assign mem_ra = AW'(rd_cnt - CW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sq_reg        <= 1'b0;
            dq_reg        <= 1'b0;
            bq_reg        <= 1'b0;
            bs_reg        <= 1'b0;
            dl_reg        <= 1'b0;
            skip_reg      <= 1'b0;
            fin_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                cnt_reg  <= cnt_next;
                sq_reg   <= sq_next;
                dq_reg   <= dq_next;
                bq_reg   <= bq_next;
                bs_reg   <= bs_next;
                dl_reg   <= dl_next;
                skip_reg <= skip_next;
                fin_reg  <= fin_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            top_reg    <= top_next;
            status_reg <= status_next;
            level_reg  <= level_wide[sxe_pkg::LEVEL_W-1:0];
        end
        if (mem_we)
        begin
            stack_mem[mem_wa] <= top_reg;
        end
        if (mem_we && (mem_wa == mem_ra))
        begin
            below_reg <= top_reg;
        end
        else
        begin
            below_reg <= stack_mem[mem_ra];
        end
    end

endmodule

`default_nettype wire

// ===== design/shell_expansion_end_scanner_unit.sv =====
// path: a result word is registered; its character word crosses the two-entry queue and then
//   the output register
// throughput: one character word per cycle while the result side is ready, set by the back end
//   doing one stack push or pop per word against a top-of-stack register and a read-ahead memory port
// reset: all scan flags and the group count clear, the scanner idles until begin_scan;
//   the group stack memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module shell_expansion_end_scanner_unit #(
    parameter int STACK_DEPTH = sxe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sxe_char_if.sink      chars,
    sxe_result_if.source  results
);

    // front: classifies each character word and does the paren lookahead
    sxe_pkg::item_t push_item;
    logic           push;
    logic           q_full;

    // queue head handed to the back end
    sxe_pkg::head_t head;
    logic           q_pop;

    sxe_front u_front (
        .chars     (chars),
        .q_full    (q_full),
        .push_item (push_item),
        .push      (push)
    );

    // short queue so the front keeps taking words, until it fills, while the result side stalls
    sxe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head)
    );

    // back: quote and escape flags, group stack, end test and output register
    sxe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (q_pop),
        .results (results)
    );

endmodule

`default_nettype wire

// ===== design/sxe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxe_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [sxe_pkg::STATUS_W-1:0] out_status,
    input wire logic [sxe_pkg::LEVEL_W-1:0]  out_level
);

    localparam int PW = $clog2(sxe_pkg::QUEUE_DEPTH + 3);

    // words accepted but not yet delivered
    logic [PW-1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pend_reg <= pend_reg + PW'(1);
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pend_reg <= pend_reg - PW'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_level))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result word without an accepted character");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PW'(sxe_pkg::QUEUE_DEPTH + 1))
        else $error("more words in flight than the queue and output register hold");

    a_end_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == sxe_pkg::ST_END) |-> out_level == '0)
        else $error("scan ended with groups still open");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= sxe_pkg::ST_IDLE)
        else $error("status code out of range");

endmodule

bind shell_expansion_end_scanner_unit sxe_checker u_sxe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_status (results.status),
    .out_level  (results.stack_level)
);

`default_nettype wire
